@@ rtl/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// Polar / rectangular converter package
// Shared widths, constants, the arctangent table and the stage payload type.
// ----------------------------------------------------------------------------
package prc_pkg;

	// Internal coordinate width: Q16.16 operands with 16 guard bits and growth.
	localparam int XW = 49;
	// Internal angle width: Q2.30 radians with headroom for the pi seed.
	localparam int ZW = 35;
	// Guard bits added by the gain pre-scale.
	localparam int GUARD = 16;

	// Reciprocal of the CORDIC gain as a fraction of 2^32.
	localparam logic [31:0] INV_GAIN = 32'd2608131496;

	localparam logic signed [ZW-1:0] PI_Q30      = 35'sd3373259426;
	localparam logic signed [ZW-1:0] TWO_PI_Q30  = 35'sd6746518852;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 35'sd1686629713;
	localparam logic signed [30:0]   PI_Q28      = 31'sd843314857;
	localparam logic signed [30:0]   HALF_PI_Q28 = 31'sd421657428;

	// Payload handed from stage to stage along the pipeline.
	typedef struct packed {
		logic                   mode;   // 0 vectoring (to polar), 1 rotation
		logic                   bypass; // result already known, chain output ignored
		logic [30:0]            byp_r;
		logic signed [30:0]     byp_a;
		logic signed [XW-1:0]   x;
		logic signed [XW-1:0]   y;
		logic signed [ZW-1:0]   z;
	} data_t;

	// atan(2^-i) in Q2.30 radians.
	function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
		logic signed [ZW-1:0] r;
		unique case (idx)
			5'd0:  r = 35'sh03243F6A8;
			5'd1:  r = 35'sh01DAC6705;
			5'd2:  r = 35'sh00FADBAFC;
			5'd3:  r = 35'sh007F56EA6;
			5'd4:  r = 35'sh003FEAB76;
			5'd5:  r = 35'sh001FFD55B;
			5'd6:  r = 35'sh000FFFAAA;
			5'd7:  r = 35'sh0007FFF55;
			5'd8:  r = 35'sh0003FFFEA;
			5'd9:  r = 35'sh0001FFFFD;
			5'd10: r = 35'sh0000FFFFF;
			5'd11: r = 35'sh00007FFFF;
			5'd12: r = 35'sh00003FFFF;
			5'd13: r = 35'sh00001FFFF;
			5'd14: r = 35'sh00000FFFF;
			5'd15: r = 35'sh000007FFF;
			5'd16: r = 35'sh000003FFF;
			5'd17: r = 35'sh000001FFF;
			5'd18: r = 35'sh000000FFF;
			5'd19: r = 35'sh0000007FF;
			5'd20: r = 35'sh0000003FF;
			5'd21: r = 35'sh0000001FF;
			5'd22: r = 35'sh0000000FF;
			5'd23: r = 35'sh00000007F;
			5'd24: r = 35'sh00000003F;
			5'd25: r = 35'sh00000001F;
			5'd26: r = 35'sh00000000F;
			5'd27: r = 35'sh000000008;
			5'd28: r = 35'sh000000004;
			5'd29: r = 35'sh000000002;
			5'd30: r = 35'sh000000001;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/prc_prep.sv @@
// ----------------------------------------------------------------------------
// Operand preparation
// Handles the axis cases, folds the angle, removes the CORDIC gain up front
// and forms the signed start vector for the cell chain (three stages).
// ----------------------------------------------------------------------------
module prc_prep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic                 operation,
	input  logic signed [30:0]   x_in,
	input  logic signed [30:0]   y_in,
	input  logic [29:0]          radius_in,
	input  logic signed [31:0]   angle_in,
	output logic                 out_valid,
	output prc_pkg::data_t       out_data
);

	localparam int ZW = prc_pkg::ZW;
	localparam int XW = prc_pkg::XW;
	localparam int PW = 63 - prc_pkg::GUARD;

	// ---- stage 1: axis cases, magnitudes, angle seed and 2pi fold ----
	logic signed [31:0]   x_ext, y_ext, x_abs, y_abs;
	logic                 x_neg, y_neg, x_zero, y_zero;
	logic signed [ZW-1:0] z4, z_fold;
	logic [30:0]          byp_r_c;
	logic signed [30:0]   byp_a_c;

	always_comb begin
		x_ext  = 32'(x_in);
		y_ext  = 32'(y_in);
		x_neg  = x_in[30];
		y_neg  = y_in[30];
		x_zero = (x_in == '0);
		y_zero = (y_in == '0);
		x_abs  = x_neg ? -x_ext : x_ext;
		y_abs  = y_neg ? -y_ext : y_ext;
		if (y_zero) begin
			byp_r_c = x_abs[30:0];
			byp_a_c = x_neg ? prc_pkg::PI_Q28 : '0;
		end else begin
			byp_r_c = y_abs[30:0];
			byp_a_c = y_neg ? -prc_pkg::HALF_PI_Q28 : prc_pkg::HALF_PI_Q28;
		end
		z4 = ZW'(angle_in) <<< 2;
		priority if (z4 > prc_pkg::PI_Q30) begin
			z_fold = z4 - prc_pkg::TWO_PI_Q30;
		end else if (z4 <= -prc_pkg::PI_Q30) begin
			z_fold = z4 + prc_pkg::TWO_PI_Q30;
		end else begin
			z_fold = z4;
		end
	end

	logic                 valid_s1, mode_s1, byp_s1, yneg_s1;
	logic [30:0]          byr_s1, xm_s1, ym_s1;
	logic signed [30:0]   bya_s1;
	logic signed [ZW-1:0] z_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= operation;
			byr_s1  <= byp_r_c;
			bya_s1  <= byp_a_c;
			if (operation) begin
				byp_s1  <= 1'b0;
				xm_s1   <= 31'(radius_in);
				ym_s1   <= '0;
				yneg_s1 <= 1'b0;
				z_s1    <= z_fold;
			end else begin
				byp_s1  <= x_zero || y_zero;
				// A negative x is turned by pi first, which negates both coordinates.
				xm_s1   <= x_abs[30:0];
				ym_s1   <= y_abs[30:0];
				yneg_s1 <= y_neg ^ x_neg;
				if (x_neg) begin
					z_s1 <= y_neg ? -prc_pkg::PI_Q30 : prc_pkg::PI_Q30;
				end else begin
					z_s1 <= '0;
				end
			end
		end
	end

	// ---- stage 2: gain pre-scale and quadrant fold ----
	logic [62:0]          prod_x, prod_y;
	logic signed [ZW-1:0] z_half;
	logic                 neg_c;

	always_comb begin
		prod_x = 63'(xm_s1) * 63'(prc_pkg::INV_GAIN);
		prod_y = 63'(ym_s1) * 63'(prc_pkg::INV_GAIN);
		priority if (mode_s1 && (z_s1 > prc_pkg::HALF_PI_Q30)) begin
			z_half = z_s1 - prc_pkg::PI_Q30;
			neg_c  = 1'b1;
		end else if (mode_s1 && (z_s1 < -prc_pkg::HALF_PI_Q30)) begin
			z_half = z_s1 + prc_pkg::PI_Q30;
			neg_c  = 1'b1;
		end else begin
			z_half = z_s1;
			neg_c  = 1'b0;
		end
	end

	logic                 valid_s2, mode_s2, byp_s2, xneg_s2, yneg_s2;
	logic [30:0]          byr_s2;
	logic signed [30:0]   bya_s2;
	logic [PW-1:0]        xp_s2, yp_s2;
	logic signed [ZW-1:0] z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			byp_s2  <= byp_s1;
			byr_s2  <= byr_s1;
			bya_s2  <= bya_s1;
			xp_s2   <= prod_x[62:prc_pkg::GUARD];
			yp_s2   <= prod_y[62:prc_pkg::GUARD];
			xneg_s2 <= neg_c;
			yneg_s2 <= yneg_s1;
			z_s2    <= z_half;
		end
	end

	// ---- stage 3: apply signs to the scaled magnitudes ----
	logic signed [XW-1:0] xs, ys;

	always_comb begin
		xs = $signed(XW'(xp_s2));
		ys = $signed(XW'(yp_s2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.mode   <= mode_s2;
			out_data.bypass <= byp_s2;
			out_data.byp_r  <= byr_s2;
			out_data.byp_a  <= bya_s2;
			out_data.x      <= xneg_s2 ? -xs : xs;
			out_data.y      <= yneg_s2 ? -ys : ys;
			out_data.z      <= z_s2;
		end
	end

endmodule

@@ rtl/prc_cell.sv @@
// ----------------------------------------------------------------------------
// CORDIC micro-rotation cell
// One shift-add rotation by atan(2^-SHIFT), registered, in vectoring or
// rotation mode as the item selects.
// ----------------------------------------------------------------------------
module prc_cell #(
	parameter int SHIFT = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  prc_pkg::data_t   in_data,
	output logic             out_valid,
	output prc_pkg::data_t   out_data
);

	localparam int XW = prc_pkg::XW;
	localparam int ZW = prc_pkg::ZW;

	logic signed [XW-1:0] dx, dy;
	logic signed [ZW-1:0] step;
	logic                 up;
	prc_pkg::data_t       nxt;

	always_comb begin
		dx   = in_data.y >>> SHIFT;
		dy   = in_data.x >>> SHIFT;
		step = prc_pkg::atan_q30(5'(SHIFT));
		// Vectoring drives y towards zero; rotation drives z towards zero.
		up   = in_data.mode ? !in_data.z[ZW-1] : in_data.y[XW-1];
		nxt  = in_data;
		if (up) begin
			nxt.x = in_data.x - dx;
			nxt.y = in_data.y + dy;
			nxt.z = in_data.z - step;
		end else begin
			nxt.x = in_data.x + dx;
			nxt.y = in_data.y - dy;
			nxt.z = in_data.z + step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

@@ rtl/prc_post.sv @@
// ----------------------------------------------------------------------------
// Result formatting
// Rounds the guard bits away, saturates, selects the fields of the item's
// mode and holds the result in the output register.
// ----------------------------------------------------------------------------
module prc_post (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  prc_pkg::data_t       in_data,
	output logic                 out_valid,
	output logic signed [30:0]   x_out,
	output logic signed [30:0]   y_out,
	output logic [30:0]          radius_out,
	output logic signed [30:0]   angle_out,
	output logic                 mode_out
);

	localparam int XW = prc_pkg::XW;
	localparam int ZW = prc_pkg::ZW;
	localparam int RW = XW - prc_pkg::GUARD;
	localparam int AW = ZW - 2;

	localparam logic signed [XW-1:0] RND   = XW'(1) <<< (prc_pkg::GUARD - 1);
	localparam logic signed [RW-1:0] C_MIN = -(RW'(1) <<< 30);
	localparam logic signed [RW-1:0] C_MAX = (RW'(1) <<< 30) - RW'(1);
	localparam logic signed [RW-1:0] R_MAX = (RW'(1) <<< 31) - RW'(1);
	localparam logic signed [AW-1:0] A_MAX = AW'(prc_pkg::PI_Q28);
	localparam logic signed [AW-1:0] A_MIN = AW'(-prc_pkg::PI_Q28 + 31'sd1);

	logic signed [XW-1:0] xsum, ysum;
	logic signed [ZW-1:0] zsum;
	logic signed [RW-1:0] xr, yr, xc, yc, rc;
	logic signed [AW-1:0] ar, ac;

	always_comb begin
		xsum = in_data.x + RND;
		ysum = in_data.y + RND;
		zsum = in_data.z + ZW'(2);
		xr   = $signed(xsum[XW-1:prc_pkg::GUARD]);
		yr   = $signed(ysum[XW-1:prc_pkg::GUARD]);
		ar   = $signed(zsum[ZW-1:2]);
		xc   = (xr < C_MIN) ? C_MIN : ((xr > C_MAX) ? C_MAX : xr);
		yc   = (yr < C_MIN) ? C_MIN : ((yr > C_MAX) ? C_MAX : yr);
		rc   = (xr < RW'(0)) ? RW'(0) : ((xr > R_MAX) ? R_MAX : xr);
		ac   = (ar < A_MIN) ? A_MIN : ((ar > A_MAX) ? A_MAX : ar);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_out <= in_data.mode;
			if (in_data.mode) begin
				x_out      <= xc[30:0];
				y_out      <= yc[30:0];
				radius_out <= '0;
				angle_out  <= '0;
			end else begin
				x_out <= '0;
				y_out <= '0;
				if (in_data.bypass) begin
					radius_out <= in_data.byp_r;
					angle_out  <= in_data.byp_a;
				end else begin
					radius_out <= rc[30:0];
					angle_out  <= ac[30:0];
				end
			end
		end
	end

endmodule

@@ rtl/polar_rectangular_converter.sv @@
// ----------------------------------------------------------------------------
// Polar / rectangular converter
// Fixed-point CORDIC converting rectangular to polar or polar to rectangular,
// chosen per item.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is free. Its pipeline holds
// three preparation stages (axis cases and angle fold, the gain pre-scale multiply,
// sign application), one CORDIC cell per iteration up to 32 and the rounding
// output register. The whole pipeline advances together, so it stalls only while
// a result waits at the output; an item is still accepted in the cycle its
// predecessor's result is taken. Coordinates are signed Q16.16 and angles signed
// Q4.28 radians; the input angle may lie within plus or minus 2pi.
module polar_rectangular_converter #(
	parameter int ITERATIONS = 30
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// x_in[30:0], y_in[61:31], radius_in[91:62], angle_in[123:92], zero pad above
	input  logic [127:0]  s_axis_tdata,
	// operation
	input  logic          s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// x_out[30:0], y_out[61:31], radius_out[92:62], angle_out[123:93], zero pad above
	output logic [127:0]  m_axis_tdata,
	// mode_out
	output logic          m_axis_tuser
);

	localparam int NCELL = (ITERATIONS > 32) ? 32 : ITERATIONS;

	logic en;
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	logic                 vchain [NCELL+1];
	prc_pkg::data_t       dchain [NCELL+1];

	prc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.operation (s_axis_tuser),
		.x_in      ($signed(s_axis_tdata[30:0])),
		.y_in      ($signed(s_axis_tdata[61:31])),
		.radius_in (s_axis_tdata[91:62]),
		.angle_in  ($signed(s_axis_tdata[123:92])),
		.out_valid (vchain[0]),
		.out_data  (dchain[0])
	);

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		prc_cell #(
			.SHIFT (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (vchain[i]),
			.in_data   (dchain[i]),
			.out_valid (vchain[i+1]),
			.out_data  (dchain[i+1])
		);
	end

	logic signed [30:0] x_out, y_out, angle_out;
	logic [30:0]        radius_out;
	logic               mode_out;

	prc_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (vchain[NCELL]),
		.in_data    (dchain[NCELL]),
		.out_valid  (m_axis_tvalid),
		.x_out      (x_out),
		.y_out      (y_out),
		.radius_out (radius_out),
		.angle_out  (angle_out),
		.mode_out   (mode_out)
	);

	assign m_axis_tdata = {4'b0000, angle_out, radius_out, y_out, x_out};
	assign m_axis_tuser = mode_out;

`ifndef ASSERT_OFF
	// A polar result carries zero rectangular fields.
	a_polar_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[61:0] == 62'd0)
		else $error("polar result has non-zero x or y field");

	// A rectangular result carries zero polar fields.
	a_rect_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[123:62] == 62'd0)
		else $error("rectangular result has non-zero radius or angle field");

	// The angle of a polar result lies in (-pi, pi].
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
		$signed(m_axis_tdata[123:93]) <= 31'sd843314857 &&
		$signed(m_axis_tdata[123:93]) >= -31'sd843314856)
		else $error("polar angle outside the range of atan2");

	// A result can only reach an empty output from the end of the cell chain.
	a_no_shortcut: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid && !vchain[NCELL] |=> !m_axis_tvalid)
		else $error("result appeared without passing the cell chain");
`endif

endmodule

@@ sim/polar_rectangular_converter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polar / rectangular converter testbench
// Sends directed and random items in both directions of conversion through
// the stream ports with random stalls on either side. Each result is checked
// field by field against a bit-exact fixed-point CORDIC predictor. A few
// directed rows carry results typed in by hand.
// ----------------------------------------------------------------------------
module polar_rectangular_converter_tb;

	localparam int ITERATIONS     = 30;
	localparam int CORDIC_STEPS   = (ITERATIONS > 32) ? 32 : ITERATIONS;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1200;

	localparam logic OP_TO_POLAR = 1'b0;
	localparam logic OP_TO_RECT  = 1'b1;

	localparam longint COORD_MAX   = 64'sd1073741823;
	localparam longint COORD_MIN   = -64'sd1073741824;
	localparam longint RADIUS_MAX  = 64'sd1073741823;
	localparam longint RADIUS_SAT  = 64'sd2147483647;
	localparam longint ANGLE_MAX   = 64'sd1686629713;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint PI_Q28      = 64'sd843314857;
	localparam longint HALF_PI_Q28 = 64'sd421657428;
	localparam longint unsigned INV_GAIN = 64'd2608131496;
	localparam int GUARD_BITS = 16;

	// atan(2^-i) in Q2.30 radians.
	localparam longint ATAN_Q30 [32] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
		64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
		64'h00000001, 64'h00000000
	};

	typedef struct packed {
		logic              op;
		logic signed [30:0] x;
		logic signed [30:0] y;
		logic [29:0]        r;
		logic signed [31:0] a;
	} conv_item_t;

	typedef struct packed {
		logic signed [30:0] x;
		logic signed [30:0] y;
		logic [30:0]        r;
		logic signed [30:0] a;
		logic               mode;
	} conv_result_t;

	typedef struct {
		conv_item_t   item;
		bit           known;
		conv_result_t want;
	} dir_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic         m_axis_tuser;

	conv_result_t pending_results[$];
	dir_row_t     dir_rows[$];
	int           mismatch_count = 0;
	int           result_count   = 0;
	int           idle_cycles    = 0;
	bit           sender_steady  = 0;

	polar_rectangular_converter #(
		.ITERATIONS(ITERATIONS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic conv_item_t mk_item(logic op, longint x, longint y, longint r, longint a);
		conv_item_t it;
		it.op = op;
		it.x  = x[30:0];
		it.y  = y[30:0];
		it.r  = r[29:0];
		it.a  = a[31:0];
		return it;
	endfunction

	function automatic conv_result_t mk_result(logic mode, longint x, longint y, longint r,
			longint a);
		conv_result_t res;
		res.x    = x[30:0];
		res.y    = y[30:0];
		res.r    = r[30:0];
		res.a    = a[30:0];
		res.mode = mode;
		return res;
	endfunction

	// Magnitude times the reciprocal gain, keeping sixteen guard bits.
	function automatic longint gain_comp(longint v);
		longint unsigned mag;
		mag = (v < 0) ? -v : v;
		mag = (mag * INV_GAIN) >> GUARD_BITS;
		return (v < 0) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint round_q16(longint v);
		return (v + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
	endfunction

	function automatic void cordic_iterate(inout longint x, inout longint y, inout longint z,
			input bit vectoring);
		longint dx, dy;
		bit     up;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			up = vectoring ? (y < 0) : (z >= 0);
			if (up) begin
				x = x - dy;
				y = y + dx;
				z = z - ATAN_Q30[i];
			end else begin
				x = x + dy;
				y = y - dx;
				z = z + ATAN_Q30[i];
			end
		end
	endfunction

	function automatic conv_result_t convert(conv_item_t it);
		conv_result_t res;
		longint xv, yv, zv, cx, cy, ro, ao, xo, yo;
		bit     flip;
		res      = '0;
		res.mode = it.op;
		if (it.op == OP_TO_POLAR) begin
			xv = longint'(it.x);
			yv = longint'(it.y);
			if (yv == 0) begin
				ro = (xv < 0) ? -xv : xv;
				ao = (xv < 0) ? PI_Q28 : 0;
			end else if (xv == 0) begin
				ro = (yv < 0) ? -yv : yv;
				ao = (yv > 0) ? HALF_PI_Q28 : -HALF_PI_Q28;
			end else begin
				zv = 0;
				// Left half-plane: turn the vector by pi and seed the angle.
				if (xv < 0) begin
					zv = (yv >= 0) ? PI_Q30 : -PI_Q30;
					xv = -xv;
					yv = -yv;
				end
				cx = gain_comp(xv);
				cy = gain_comp(yv);
				cordic_iterate(cx, cy, zv, 1'b1);
				ro = round_q16(cx);
				ao = (zv + 2) >>> 2;
				if (ao < -PI_Q28 + 1)
					ao = -PI_Q28 + 1;
				if (ao > PI_Q28)
					ao = PI_Q28;
			end
			if (ro < 0)
				ro = 0;
			if (ro > RADIUS_SAT)
				ro = RADIUS_SAT;
			res.r = ro[30:0];
			res.a = ao[30:0];
		end else begin
			zv = longint'(it.a);
			zv = zv * 4;
			flip = 1'b0;
			if (zv > PI_Q30)
				zv = zv - TWO_PI_Q30;
			else if (zv <= -PI_Q30)
				zv = zv + TWO_PI_Q30;
			if (zv > HALF_PI_Q30) begin
				zv = zv - PI_Q30;
				flip = 1'b1;
			end else if (zv < -HALF_PI_Q30) begin
				zv = zv + PI_Q30;
				flip = 1'b1;
			end
			xv = longint'(it.r);
			cx = gain_comp(flip ? -xv : xv);
			cy = 0;
			cordic_iterate(cx, cy, zv, 1'b0);
			xo = round_q16(cx);
			yo = round_q16(cy);
			xo = (xo > COORD_MAX) ? COORD_MAX : ((xo < COORD_MIN) ? COORD_MIN : xo);
			yo = (yo > COORD_MAX) ? COORD_MAX : ((yo < COORD_MIN) ? COORD_MIN : yo);
			res.x = xo[30:0];
			res.y = yo[30:0];
		end
		return res;
	endfunction

	function automatic longint rand_coord();
		longint v;
		case ($urandom_range(0, 7))
			0: v = 0;
			1: v = COORD_MIN;
			2: v = COORD_MAX;
			3: v = longint'($urandom_range(0, 511)) - 256;
			4: v = longint'($urandom_range(0, 13107200)) - 6553600;
			default: begin
				v = longint'($urandom) & 64'h7FFF_FFFF;
				if (v > COORD_MAX)
					v = v - 64'sd2147483648;
			end
		endcase
		return v;
	endfunction

	function automatic longint rand_angle();
		longint v;
		case ($urandom_range(0, 9))
			0: v = ANGLE_MAX;
			1: v = -ANGLE_MAX;
			2: v = ($urandom_range(0, 1) != 0) ? PI_Q28 : -PI_Q28;
			3: v = (($urandom_range(0, 1) != 0) ? HALF_PI_Q28 : -HALF_PI_Q28)
				+ longint'($urandom_range(0, 2)) - 1;
			default: v = longint'($urandom_range(0, 32'd3373259426)) - ANGLE_MAX;
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string what);
		$display("MISMATCH at result %0d: %s", result_count, what);
		mismatch_count++;
	endtask

	task automatic check_result(conv_result_t got);
		conv_result_t want;
		result_count++;
		if (pending_results.size() == 0) begin
			report_mismatch("result arrived with no item outstanding");
		end else begin
			want = pending_results.pop_front();
			if (got.x !== want.x)
				report_mismatch($sformatf("x_out %0d, expected %0d", got.x, want.x));
			if (got.y !== want.y)
				report_mismatch($sformatf("y_out %0d, expected %0d", got.y, want.y));
			if (got.r !== want.r)
				report_mismatch($sformatf("radius_out %0d, expected %0d", got.r, want.r));
			if (got.a !== want.a)
				report_mismatch($sformatf("angle_out %0d, expected %0d", got.a, want.a));
			if (got.mode !== want.mode)
				report_mismatch($sformatf("mode_out %0b, expected %0b", got.mode, want.mode));
		end
	endtask

	// Presents one item after a random gap and returns at the edge that takes it.
	task automatic send_item(conv_item_t it, conv_result_t want);
		int gap;
		if ($urandom_range(0, 63) == 0)
			sender_steady = !sender_steady;
		gap = sender_steady ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, it.a, it.r, it.y, it.x};
		s_axis_tuser  <= it.op;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(want);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Result side: random stalls, with the odd stretch of steady acceptance.
	initial begin
		int stall;
		bit steady;
		steady = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 63) == 0)
				steady = !steady;
			stall = steady ? 0 : $urandom_range(0, 15);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			check_result(mk_result(m_axis_tuser, longint'($signed(m_axis_tdata[30:0])),
				longint'($signed(m_axis_tdata[61:31])), longint'(m_axis_tdata[92:62]),
				longint'($signed(m_axis_tdata[123:93]))));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("Watchdog expired after %0d idle cycles", idle_cycles);
					$display("Test completed with failures");
					$finish;
				end
			end
		end
	end

	initial begin
		conv_item_t it;
		longint     r;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		m_axis_tready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Axis cases and the zero radius have results that are known outright.
		dir_rows.push_back('{mk_item(OP_TO_POLAR, 0, 0, 0, 0), 1'b1,
			mk_result(OP_TO_POLAR, 0, 0, 0, 0)});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, -65536, 0, 0, 0), 1'b1,
			mk_result(OP_TO_POLAR, 0, 0, 65536, PI_Q28)});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, COORD_MIN, 0, RADIUS_MAX, -1), 1'b1,
			mk_result(OP_TO_POLAR, 0, 0, -COORD_MIN, PI_Q28)});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, COORD_MAX, 0, 0, 0), 1'b1,
			mk_result(OP_TO_POLAR, 0, 0, COORD_MAX, 0)});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, 0, COORD_MAX, 0, 0), 1'b1,
			mk_result(OP_TO_POLAR, 0, 0, COORD_MAX, HALF_PI_Q28)});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, 0, COORD_MIN, 0, 0), 1'b1,
			mk_result(OP_TO_POLAR, 0, 0, -COORD_MIN, -HALF_PI_Q28)});
		dir_rows.push_back('{mk_item(OP_TO_RECT, 0, 0, 0, 0), 1'b1,
			mk_result(OP_TO_RECT, 0, 0, 0, 0)});
		dir_rows.push_back('{mk_item(OP_TO_RECT, COORD_MIN, -1, 0, -ANGLE_MAX), 1'b1,
			mk_result(OP_TO_RECT, 0, 0, 0, 0)});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, 1, 1, 0, 0), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, -1, 1, 0, 0), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, -1, -1, 0, 0), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, COORD_MIN, COORD_MIN, 0, 0), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, COORD_MAX, COORD_MAX, 0, 0), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, COORD_MIN, 1, 0, 0), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_POLAR, COORD_MIN, -1, 0, 0), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_RECT, 0, 0, RADIUS_MAX, 0), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_RECT, 0, 0, RADIUS_MAX, HALF_PI_Q28), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_RECT, 0, 0, RADIUS_MAX, PI_Q28), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_RECT, 0, 0, RADIUS_MAX, -PI_Q28), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_RECT, 0, 0, RADIUS_MAX, ANGLE_MAX), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_RECT, 0, 0, RADIUS_MAX, -ANGLE_MAX), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_RECT, 0, 0, 65536, PI_Q28 + 1), 1'b0, '0});
		dir_rows.push_back('{mk_item(OP_TO_RECT, 0, 0, 12345, -HALF_PI_Q28 - 1), 1'b0, '0});

		foreach (dir_rows[i])
			send_item(dir_rows[i].item,
				dir_rows[i].known ? dir_rows[i].want : convert(dir_rows[i].item));
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// Halfway through, let the pipeline run completely dry once more.
			if (n == RANDOM_ITEMS / 2)
				drain_results();
			case ($urandom_range(0, 3))
				0: r = 0;
				1: r = RADIUS_MAX;
				2: r = longint'($urandom_range(0, 6553600));
				default: r = longint'($urandom) & RADIUS_MAX;
			endcase
			// The unused pair of fields carries random content as well.
			it = mk_item(1'($urandom_range(0, 1)), rand_coord(), rand_coord(), r,
				rand_angle());
			send_item(it, convert(it));
		end
		drain_results();
		repeat (ITERATIONS + 8) @(posedge clk);

		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
